// ===== rtl/core/prav_pkg.sv =====
// Shared widths and constants for the pose running-average block.
`timescale 1ns / 1ps
`default_nettype none

package prav_pkg;

    // Field widths
    localparam int POS_W = 16;
    localparam int ANG_W = 16;
    localparam int CNT_W = 16;
    localparam int ERR_W = 17;

    // Running sums and the serial divider
    localparam int SUM_W      = 32;
    localparam int DIV_STEP_W = $clog2(SUM_W);

    // Shift-add multiplier: 31-bit multiplicand, one multiplier bit a cycle
    localparam int MCAND_W    = 31;
    localparam int MPLIER_W   = 16;
    localparam int PROD_W     = MCAND_W + MPLIER_W;
    localparam int MUL_STEP_W = $clog2(MPLIER_W);
    localparam int SQ_W       = 2 * POS_W;

    // Digit-by-digit square root: two radicand bits a cycle
    localparam int RAD_W       = 34;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SQ_REM_W    = ROOT_W + 1;
    localparam int SQRT_STEP_W = $clog2(ROOT_W);

    // Observation count saturates here
    localparam logic [CNT_W-1:0] MAX_COUNT = 16'd65535;

    // Heading units: 32768 stands for pi
    localparam logic signed [ANG_W:0] PI_UNITS      = 17'sd32768;
    localparam logic        [ANG_W:0] HALF_PI_UNITS = 17'd16384;

    // pi scaled by 2^29; the heading term is (d * PI_Q29 + 2^33) >> 34
    localparam logic [MCAND_W-1:0] PI_Q29     = 31'd1686629713;
    localparam int                 ATERM_SH   = 34;
    localparam logic [PROD_W-1:0]  ATERM_RND  = 47'd8589934592;
    localparam int                 ATERM_W    = PROD_W - ATERM_SH;

    localparam logic [ERR_W-1:0] ERR_MAX = 17'd131071;

endpackage : prav_pkg

`default_nettype wire

// ===== rtl/core/prav_div.sv =====
// Bit-serial restoring divider: signed running sum by unsigned count.
`timescale 1ns / 1ps
`default_nettype none

module prav_div
    import prav_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [CNT_W-1:0] divisor,
    output logic                    done,
    output logic        [POS_W-1:0] quotient
);

    localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(SUM_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]      work_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      den_reg;
    logic                  neg_reg;
    logic [POS_W-1:0]      quo_reg;

    logic [SUM_W-1:0] mag;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;
    logic             ge;
    logic [CNT_W-1:0] rem_next;
    logic [SUM_W-1:0] work_next;
    logic [POS_W-1:0] quo_mag;
    logic [POS_W-1:0] quo_fin;
    logic             last;

    // Take the magnitude of the dividend; the sign is reapplied at the end
    assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

    // One quotient bit a cycle: shift in the next dividend bit, try a subtract
    assign rem_sh    = {rem_reg, work_reg[SUM_W-1]};
    assign ge        = (rem_sh >= {1'b0, den_reg});
    assign rem_sub   = rem_sh - {1'b0, den_reg};
    assign rem_next  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    assign work_next = {work_reg[SUM_W-2:0], ge};
    assign last      = busy_reg && (step_reg == DIV_LAST);

    // Truncate toward zero: negate the low bits of the magnitude quotient
    assign quo_mag = work_next[POS_W-1:0];
    assign quo_fin = neg_reg ? (~quo_mag + POS_W'(1)) : quo_mag;

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= last;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (last)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + DIV_STEP_W'(1);
            end
        end
    end

    // Load and shift the datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= mag;
            rem_reg  <= '0;
            den_reg  <= divisor;
            neg_reg  <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
        if (last)
        begin
            quo_reg <= quo_fin;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : prav_div

`default_nettype wire

// ===== rtl/core/prav_mul.sv =====
// Shift-add multiplier taking one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prav_mul
    import prav_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic                done,
    output logic [PROD_W-1:0]   prod
);

    localparam logic [MUL_STEP_W-1:0] MUL_LAST = MUL_STEP_W'(MPLIER_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [MUL_STEP_W-1:0] step_reg;
    logic [MCAND_W-1:0]    mcand_reg;
    logic [MCAND_W-1:0]    acc_reg;
    logic [MPLIER_W-1:0]   lo_reg;

    logic [MCAND_W:0] part_sum;
    logic             last;

    // Add the multiplicand when the current multiplier bit is set, then shift right
    assign part_sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign last     = busy_reg && (step_reg == MUL_LAST);

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= last;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (last)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + MUL_STEP_W'(1);
            end
        end
    end

    // Product builds up in acc and lo; it holds once the steps are over
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            acc_reg   <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg <= part_sum[MCAND_W:1];
            lo_reg  <= {part_sum[0], lo_reg[MPLIER_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg, lo_reg};

endmodule : prav_mul

`default_nettype wire

// ===== rtl/core/prav_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prav_sqrt
    import prav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam logic [SQRT_STEP_W-1:0] SQRT_LAST = SQRT_STEP_W'(ROOT_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [SQRT_STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]       rad_reg;
    logic [SQ_REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]      root_reg;

    logic [SQ_REM_W+1:0] rem_sh;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] rem_sub;
    logic                ge;
    logic                last;

    // Bring down two bits, try subtracting 4*root + 1
    assign rem_sh  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;
    assign last    = busy_reg && (step_reg == SQRT_LAST);

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= last;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (last)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SQRT_STEP_W'(1);
            end
        end
    end

    // Shift the radicand out and the root bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule : prav_sqrt

`default_nettype wire

// ===== rtl/core/pose_running_average.sv =====
// Top level: running mean of observed poses with heading smoothing and fit error.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   obs     | in        | in_valid, in_stall | obs_x, obs_y, obs_angle
//   result  | out       | out_valid, out_stall | mean_x, mean_y, mean_angle, fit_error,
//           |           |                    | seen_count
//
// A transaction runs from acceptance through the two parallel 32-step dividers, the
// 16-step squarers and the 17-step square root, each entered from its own start state,
// and ends in a hand-over state that waits for a free output register.
// The heading term's multiply runs alongside the dividers.
// Reset clears sums, count and centre to zero and leaves the output empty.
// in_stall is high while an observation is in work; a stalled result holds in the
// output register while the next observation is accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none

module pose_running_average
    import prav_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [POS_W-1:0] obs_x,
    input  logic signed [POS_W-1:0] obs_y,
    input  logic signed [ANG_W-1:0] obs_angle,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] mean_x,
    output logic signed [POS_W-1:0] mean_y,
    output logic signed [ANG_W-1:0] mean_angle,
    output logic        [ERR_W-1:0] fit_error,
    output logic        [CNT_W-1:0] seen_count
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DIV_START  = 3'd1;
    localparam logic [2:0] S_DIV        = 3'd2;
    localparam logic [2:0] S_SQ_START   = 3'd3;
    localparam logic [2:0] S_SQ         = 3'd4;
    localparam logic [2:0] S_ROOT_START = 3'd5;
    localparam logic [2:0] S_ROOT       = 3'd6;
    localparam logic [2:0] S_FIN        = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic        [CNT_W-1:0] count_reg;
    logic signed [POS_W-1:0] center_x_reg;
    logic signed [POS_W-1:0] center_y_reg;
    logic signed [ANG_W-1:0] center_angle_reg;
    logic signed [POS_W-1:0] obs_x_reg;
    logic signed [POS_W-1:0] obs_y_reg;
    logic        [ANG_W-1:0] diff_reg;

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] mean_x_reg;
    logic signed [POS_W-1:0] mean_y_reg;
    logic signed [ANG_W-1:0] mean_angle_reg;
    logic        [ERR_W-1:0] fit_error_reg;
    logic        [CNT_W-1:0] seen_count_reg;

    logic in_accept;
    logic out_free;

    // Heading datapath
    logic signed [ANG_W:0]   ang_diff;
    logic        [ANG_W:0]   ang_abs;
    logic                    fold;
    logic                    oa_pos;
    logic signed [ANG_W:0]   oa_ext;
    logic signed [ANG_W:0]   oa_fold;
    logic signed [ANG_W+1:0] half_sum;
    logic signed [ANG_W+1:0] half_rnd;

    // Distance datapath
    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] dy;
    logic        [POS_W:0] dx_abs;
    logic        [POS_W:0] dy_abs;
    logic [RAD_W-1:0]      radicand;
    logic [PROD_W-1:0]     ang_rnd;
    logic [ATERM_W-1:0]    aterm;
    logic [ROOT_W:0]       err_sum;
    logic [ERR_W-1:0]      err_sat;

    // Unit handshakes
    logic                  div_start;
    logic                  div_x_done;
    logic                  div_y_done;
    logic [POS_W-1:0]      quo_x;
    logic [POS_W-1:0]      quo_y;
    logic                  sq_start;
    logic                  sq_x_done;
    logic                  sq_y_done;
    logic [PROD_W-1:0]     sq_x_prod;
    logic [PROD_W-1:0]     sq_y_prod;
    logic                  ang_done;
    logic [PROD_W-1:0]     ang_prod;
    logic                  root_start;
    logic                  root_done;
    logic [ROOT_W-1:0]     root;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Fold the observed heading and form the truncated half-sum
    assign ang_diff = {center_angle_reg[ANG_W-1], center_angle_reg}
                    - {obs_angle[ANG_W-1], obs_angle};
    assign ang_abs  = ang_diff[ANG_W] ? (~ang_diff + (ANG_W+1)'(1)) : ang_diff;
    assign fold     = (ang_abs > HALF_PI_UNITS);
    assign oa_pos   = !obs_angle[ANG_W-1] && (obs_angle != '0);
    assign oa_ext   = {obs_angle[ANG_W-1], obs_angle};
    assign oa_fold  = !fold ? oa_ext : (oa_pos ? (oa_ext - PI_UNITS) : (oa_ext + PI_UNITS));
    assign half_sum = {{2{center_angle_reg[ANG_W-1]}}, center_angle_reg}
                    + {oa_fold[ANG_W], oa_fold};
    assign half_rnd = half_sum + {{(ANG_W+1){1'b0}}, half_sum[ANG_W+1]};

    // Offsets from the new centre to the observation
    assign dx     = {center_x_reg[POS_W-1], center_x_reg} - {obs_x_reg[POS_W-1], obs_x_reg};
    assign dy     = {center_y_reg[POS_W-1], center_y_reg} - {obs_y_reg[POS_W-1], obs_y_reg};
    assign dx_abs = dx[POS_W] ? (~dx + (POS_W+1)'(1)) : dx;
    assign dy_abs = dy[POS_W] ? (~dy + (POS_W+1)'(1)) : dy;

    assign radicand = RAD_W'(sq_x_prod[SQ_W-1:0]) + RAD_W'(sq_y_prod[SQ_W-1:0]);

    // Heading term rounded to 1/1024 rad, then saturate the total
    assign ang_rnd = ang_prod + ATERM_RND;
    assign aterm   = ang_rnd[PROD_W-1:ATERM_SH];
    assign err_sum = {1'b0, root} + (ROOT_W+1)'(aterm);
    assign err_sat = (err_sum > (ROOT_W+1)'(ERR_MAX)) ? ERR_MAX : err_sum[ERR_W-1:0];

    assign div_start  = (state_reg == S_DIV_START);
    assign sq_start   = (state_reg == S_SQ_START);
    assign root_start = (state_reg == S_ROOT_START);

    // Sequence one observation through the serial units
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_accept) state_next = S_DIV_START;
            S_DIV_START:  state_next = S_DIV;
            S_DIV:        if (div_x_done) state_next = S_SQ_START;
            S_SQ_START:   state_next = S_SQ;
            S_SQ:         if (sq_x_done) state_next = S_ROOT_START;
            S_ROOT_START: state_next = S_ROOT;
            S_ROOT:       if (root_done) state_next = S_FIN;
            S_FIN:        if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Hold the running state: sums, count and centre
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            count_reg        <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_angle_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                center_angle_reg <= half_rnd[ANG_W:1];
                if (count_reg < MAX_COUNT)
                begin
                    sum_x_reg <= sum_x_reg + SUM_W'(obs_x);
                    sum_y_reg <= sum_y_reg + SUM_W'(obs_y);
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if ((state_reg == S_DIV) && div_x_done)
            begin
                center_x_reg <= quo_x;
                center_y_reg <= quo_y;
            end
        end
    end

    // Capture the observation for the distance and heading terms
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            obs_x_reg <= obs_x;
            obs_y_reg <= obs_y;
            diff_reg  <= ang_abs[ANG_W-1:0];
        end
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            mean_x_reg     <= center_x_reg;
            mean_y_reg     <= center_y_reg;
            mean_angle_reg <= center_angle_reg;
            fit_error_reg  <= err_sat;
            seen_count_reg <= count_reg;
        end
    end

    // Centre position: x and y dividers run side by side
    prav_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_x_reg),
        .divisor  (count_reg),
        .done     (div_x_done),
        .quotient (quo_x)
    );

    prav_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_y_reg),
        .divisor  (count_reg),
        .done     (div_y_done),
        .quotient (quo_y)
    );

    // Heading difference times pi, alongside the division
    prav_mul u_mul_ang (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .mcand  (PI_Q29),
        .mplier (diff_reg),
        .done   (ang_done),
        .prod   (ang_prod)
    );

    // Squares of the offsets
    prav_mul u_mul_dx (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .mcand  (MCAND_W'(dx_abs[POS_W-1:0])),
        .mplier (dx_abs[POS_W-1:0]),
        .done   (sq_x_done),
        .prod   (sq_x_prod)
    );

    prav_mul u_mul_dy (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .mcand  (MCAND_W'(dy_abs[POS_W-1:0])),
        .mplier (dy_abs[POS_W-1:0]),
        .done   (sq_y_done),
        .prod   (sq_y_prod)
    );

    prav_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    assign out_valid  = out_valid_reg;
    assign mean_x     = mean_x_reg;
    assign mean_y     = mean_y_reg;
    assign mean_angle = mean_angle_reg;
    assign fit_error  = fit_error_reg;
    assign seen_count = seen_count_reg;

`ifndef SYNTHESIS
    // The two dividers start together and must finish together
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_done == div_y_done)
        else $error("x and y dividers out of step");

    // The squarers and the heading multiply finish only while their results are awaited
    a_unit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_x_done || sq_y_done || ang_done) |->
            (state_reg == S_SQ) || (state_reg == S_DIV))
        else $error("multiplier finished outside its wait state");

    // An accepted observation below saturation advances the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (count_reg < MAX_COUNT)) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("observation count did not advance");

    // A result appears only from the hand-over state
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside hand-over");
`endif

endmodule : pose_running_average

`default_nettype wire
